>>> rtl/moma_pkg.sv
// Shared types, codes and the message length table of the MIDI-out message assembler.
`timescale 1ns / 1ps

package moma_pkg;

	localparam logic [7:0] ST_SYSEX  = 8'hF0;
	localparam logic [7:0] ST_EOX    = 8'hF7;
	localparam logic [7:0] RT_FIRST  = 8'hF8;
	localparam logic [7:0] ST_NONE   = 8'h00;
	localparam int         SYSEX_MIN = 4;

	typedef enum logic [2:0] {
		KIND_RT    = 3'd0,
		KIND_MSG   = 3'd1,
		KIND_SXB   = 3'd2,
		KIND_SHORT = 3'd3,
		KIND_INTR  = 3'd4,
		KIND_FULL  = 3'd5
	} kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  latch;
		logic  emit;
		kind_t kind;
		logic  last;
		logic  store;
		logic  set_rs;
		logic  clr_rs;
		logic  clr_fill;
		logic  rd_mem;
		logic  inc_ptr;
		logic  clr_ptr;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_rt;
		logic is_status;
		logic rs_sysex;
		logic fill_lt_min;
		logic fill_zero;
		logic fill_full;
		logic byte_len_one;
		logic byte_is_eox;
		logic complete;
		logic ptr_at_end;
		logic out_free;
	} sts_t;

	// Standard message length of a status byte; zero means never complete.
	function automatic logic [1:0] msg_len(input logic [7:0] s);
		logic [1:0] len;
		begin
			len = 2'd0;
			if (s >= 8'h80 && s <= 8'hBF) begin
				len = 2'd3;
			end else if (s >= 8'hC0 && s <= 8'hDF) begin
				len = 2'd2;
			end else if (s >= 8'hE0 && s <= 8'hEF) begin
				len = 2'd3;
			end else if (s == 8'hF1 || s == 8'hF3) begin
				len = 2'd2;
			end else if (s == 8'hF2) begin
				len = 2'd3;
			end else if (s == 8'hF6) begin
				len = 2'd1;
			end
			return len;
		end
	endfunction

endpackage

>>> rtl/moma_dp.sv
// Datapath of the MIDI-out message assembler: running status, byte store and output register.
`timescale 1ns / 1ps

module moma_dp #(
	parameter int BUF_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        byte_in,
	input  logic              out_stall,
	input  moma_pkg::cmd_t    cmd,
	output moma_pkg::sts_t    sts,
	output logic              out_valid,
	output logic [2:0]        kind,
	output logic [7:0]        status_byte,
	output logic [6:0]        first_data,
	output logic [6:0]        second_data,
	output logic [1:0]        data_count,
	output logic [6:0]        sysex_byte,
	output logic              last
);

	localparam int FILL_W = $clog2(BUF_DEPTH + 1);
	localparam int PTR_W  = $clog2(BUF_DEPTH);

	logic [7:0]        byte_q;
	logic [7:0]        rs_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] ptr_q;
	logic [6:0]        d0_q;
	logic [6:0]        d1_q;
	logic [6:0]        rd_data_q;
	logic [6:0]        mem [BUF_DEPTH];

	logic              out_valid_q;
	logic [2:0]        kind_q;
	logic [7:0]        status_q;
	logic [6:0]        first_q;
	logic [6:0]        second_q;
	logic [1:0]        count_q;
	logic [6:0]        sysex_q;
	logic              last_q;

	logic [FILL_W:0]   fill_inc;
	logic [FILL_W:0]   rs_len;

	// One bit wider so that a full store never wraps onto a zero length.
	assign fill_inc = {1'b0, fill_q} + {{FILL_W{1'b0}}, 1'b1};
	assign rs_len   = {{(FILL_W - 1){1'b0}}, moma_pkg::msg_len(rs_q)};

	assign sts.is_rt        = byte_q >= moma_pkg::RT_FIRST;
	assign sts.is_status    = byte_q[7];
	assign sts.rs_sysex     = rs_q == moma_pkg::ST_SYSEX;
	assign sts.fill_lt_min  = fill_q < FILL_W'(moma_pkg::SYSEX_MIN);
	assign sts.fill_zero    = fill_q == '0;
	assign sts.fill_full    = fill_q == FILL_W'(BUF_DEPTH);
	assign sts.byte_len_one = moma_pkg::msg_len(byte_q) == 2'd1;
	assign sts.byte_is_eox  = byte_q == moma_pkg::ST_EOX;
	assign sts.complete     = (rs_q != moma_pkg::ST_SYSEX) && (fill_inc == rs_len);
	assign sts.ptr_at_end   = (ptr_q + FILL_W'(1)) == fill_q;
	assign sts.out_free     = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			byte_q <= byte_in;
		end
		if (cmd.store && fill_q == '0) begin
			d0_q <= byte_q[6:0];
		end
		if (cmd.store && fill_q == FILL_W'(1)) begin
			d1_q <= byte_q[6:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[fill_q[PTR_W-1:0]] <= byte_q[6:0];
		end
		if (cmd.rd_mem) begin
			rd_data_q <= mem[ptr_q[PTR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q   <= moma_pkg::ST_NONE;
			fill_q <= '0;
			ptr_q  <= '0;
		end else begin
			if (cmd.clr_rs) begin
				rs_q <= moma_pkg::ST_NONE;
			end else if (cmd.set_rs) begin
				rs_q <= byte_q;
			end
			if (cmd.clr_fill) begin
				fill_q <= '0;
			end else if (cmd.store) begin
				fill_q <= fill_inc[FILL_W-1:0];
			end
			if (cmd.clr_ptr) begin
				ptr_q <= '0;
			end else if (cmd.inc_ptr) begin
				ptr_q <= ptr_q + FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q <= cmd.kind;
			last_q <= cmd.last;
			case (cmd.kind)
				moma_pkg::KIND_MSG: begin
					status_q <= rs_q;
					count_q  <= fill_q[1:0];
					first_q  <= (fill_q != '0) ? d0_q : 7'd0;
					second_q <= (fill_q > FILL_W'(1)) ? d1_q : 7'd0;
					sysex_q  <= '0;
				end
				moma_pkg::KIND_SXB: begin
					status_q <= moma_pkg::ST_SYSEX;
					count_q  <= '0;
					first_q  <= '0;
					second_q <= '0;
					sysex_q  <= rd_data_q;
				end
				default: begin
					status_q <= byte_q;
					count_q  <= '0;
					first_q  <= '0;
					second_q <= '0;
					sysex_q  <= '0;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign status_byte = status_q;
	assign first_data  = first_q;
	assign second_data = second_q;
	assign data_count  = count_q;
	assign sysex_byte  = sysex_q;
	assign last        = last_q;

endmodule

>>> rtl/moma_ctrl.sv
// Controller state machine of the MIDI-out message assembler.
`timescale 1ns / 1ps

module moma_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  moma_pkg::sts_t sts,
	output moma_pkg::cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_SX_RD  = 6'b000100,
		S_SX_OUT = 6'b001000,
		S_SX_END = 6'b010000,
		S_CHECK  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = state_q != S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.is_rt) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						cmd.kind = moma_pkg::KIND_RT;
						cmd.last = 1'b1;
						state_d  = S_IDLE;
					end
				end else if (sts.is_status) begin
					if (sts.rs_sysex && !sts.fill_lt_min) begin
						state_d = S_SX_RD;
					end else if (sts.rs_sysex || !sts.fill_zero) begin
						// A one-byte message follows only for a status whose length is one.
						if (sts.out_free) begin
							cmd.emit     = 1'b1;
							cmd.kind     = sts.rs_sysex ? moma_pkg::KIND_SHORT
							                            : moma_pkg::KIND_INTR;
							cmd.last     = !sts.byte_len_one;
							cmd.set_rs   = 1'b1;
							cmd.clr_fill = 1'b1;
							state_d      = S_CHECK;
						end
					end else begin
						cmd.set_rs = 1'b1;
						state_d    = S_CHECK;
					end
				end else if (sts.fill_full) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						cmd.kind = moma_pkg::KIND_FULL;
						cmd.last = 1'b1;
						state_d  = S_CHECK;
					end
				end else begin
					cmd.store = 1'b1;
					state_d   = S_CHECK;
				end
			end
			S_SX_RD: begin
				cmd.rd_mem = 1'b1;
				state_d    = S_SX_OUT;
			end
			S_SX_OUT: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.kind    = moma_pkg::KIND_SXB;
					cmd.last    = sts.ptr_at_end && (sts.byte_is_eox || !sts.byte_len_one);
					cmd.inc_ptr = 1'b1;
					state_d     = sts.ptr_at_end ? S_SX_END : S_SX_RD;
				end
			end
			S_SX_END: begin
				cmd.clr_fill = 1'b1;
				cmd.clr_ptr  = 1'b1;
				if (sts.byte_is_eox) begin
					cmd.clr_rs = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.set_rs = 1'b1;
					state_d    = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.complete) begin
					if (sts.out_free) begin
						cmd.emit     = 1'b1;
						cmd.kind     = moma_pkg::KIND_MSG;
						cmd.last     = 1'b1;
						cmd.clr_fill = 1'b1;
						state_d      = S_IDLE;
					end
				end else begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/midi_out_message_assembler_unit.sv
// Top level of the MIDI-out message assembler: controller plus datapath.
`timescale 1ns / 1ps

// Usage: raw MIDI-out bytes enter on the input channel (in_valid, in_stall, byte_in),
// one word at a time. Result words leave on the output channel (out_valid, out_stall
// and the result fields); last marks the final result caused by one input byte.
// A word is taken on a rising edge with valid high and stall low.
// Flow: a byte is taken in idle and decoded in the next cycle; where a result is
// due, it is written to the output register from the decode state; a data byte that
// completes a message produces it from the check state that follows.
// A SysEx run walks the byte store; each buffered byte takes a registered memory
// read and then a load of the output register. A run closed by a status byte
// other than an end-of-exclusive then also passes through the check state.
// in_stall is high whenever the controller is not idle.
// Reset clears the running status, the fill count and the output valid; the byte
// store needs no clearing, since only entries below the fill count are read.
// While out_stall is high with a valid word, that word holds and the controller waits at the
// next result it has to emit.

module midi_out_message_assembler_unit #(
	parameter int BUF_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] byte_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] kind,
	output logic [7:0] status_byte,
	output logic [6:0] first_data,
	output logic [6:0] second_data,
	output logic [1:0] data_count,
	output logic [6:0] sysex_byte,
	output logic       last
);

	moma_pkg::cmd_t cmd;
	moma_pkg::sts_t sts;

	moma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	moma_dp #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_in     (byte_in),
		.out_stall   (out_stall),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.kind        (kind),
		.status_byte (status_byte),
		.first_data  (first_data),
		.second_data (second_data),
		.data_count  (data_count),
		.sysex_byte  (sysex_byte),
		.last        (last)
	);

endmodule

>>> rtl/moma_chk.sv
// Port-level checker of the MIDI-out message assembler and its bind to the top level.
`timescale 1ns / 1ps

module moma_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] byte_in,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] kind,
	input logic [7:0] status_byte,
	input logic [6:0] first_data,
	input logic [6:0] second_data,
	input logic [1:0] data_count,
	input logic [6:0] sysex_byte,
	input logic       last
);

	// A stalled result word stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(status_byte)
			&& $stable(sysex_byte) && $stable(last))
		else $error("stalled result word changed");

	// After taking a byte the block is busy decoding it.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while previous byte still in decode");

	// Realtime bytes, completed messages and full-store results are always the final result of their byte.
	a_final_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == moma_pkg::KIND_RT || kind == moma_pkg::KIND_MSG
			|| kind == moma_pkg::KIND_FULL) |-> last)
		else $error("realtime, message or full result not marked last");

	// Only a message carries data bytes.
	a_data_only_msg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != moma_pkg::KIND_MSG |->
			first_data == 7'd0 && second_data == 7'd0 && data_count == 2'd0)
		else $error("data bytes on a non-message result");

	// SysEx bytes are reported under the SysEx status.
	a_sysex_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == moma_pkg::KIND_SXB |-> status_byte == moma_pkg::ST_SYSEX)
		else $error("sysex byte result without sysex status");

endmodule

bind midi_out_message_assembler_unit moma_chk u_moma_chk (.*);

>>> verif/midi_out_message_assembler_unit_test.sv
// Self-checking testbench of the MIDI-out message assembler with its own result predictor.
`timescale 1ns / 1ps

module midi_out_message_assembler_unit_test;

	localparam int STORE_DEPTH = 32;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PAUSE_MARK  = -1;
	localparam int ITEM_GOAL   = 470;
	localparam int HOLD_AT     = 120;
	localparam int HOLD_CYCLES = 300;
	localparam int CALM_FIRST  = 300;
	localparam int CALM_LAST   = 380;
	localparam int DRAIN_WAIT  = 100;

	typedef struct packed {
		moma_pkg::kind_t kind;
		logic [7:0]      status;
		logic [6:0]      d1;
		logic [6:0]      d2;
		logic [1:0]      cnt;
		logic [6:0]      sx;
		logic            last;
	} midi_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] byte_in = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] kind;
	logic [7:0] status_byte;
	logic [6:0] first_data;
	logic [6:0] second_data;
	logic [1:0] data_count;
	logic [6:0] sysex_byte;
	logic       last;

	// Bytes still to be sent; PAUSE_MARK makes the sender wait until all results are in.
	int         stim_q[$];
	midi_word_t expected_words[$];

	// Predictor state.
	logic [7:0] run_status;
	logic [6:0] byte_store [STORE_DEPTH];
	int         fill_level;

	int         bytes_taken = 0;
	int         words_predicted = 0;
	int         words_seen = 0;
	int         error_count = 0;
	int         cycle_count = 0;
	logic       calm;

	bit         drv_took;
	bit         drv_next;
	int         drv_words;
	int         hold_left;
	bit         hold_done;
	midi_word_t got_word;
	midi_word_t want_word;
	logic [7:0] voice_status = 8'h90;
	bit         pause_placed = 1'b0;

	midi_out_message_assembler_unit #(
		.BUF_DEPTH(STORE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_in(byte_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.status_byte(status_byte),
		.first_data(first_data),
		.second_data(second_data),
		.data_count(data_count),
		.sysex_byte(sysex_byte),
		.last(last)
	);

	// Neither side idles while this window of input words passes.
	assign calm = bytes_taken >= CALM_FIRST && bytes_taken < CALM_LAST;

	function automatic midi_word_t make_word(moma_pkg::kind_t k, logic [7:0] s,
			logic [6:0] a, logic [6:0] c, logic [1:0] n, logic [6:0] x);
		midi_word_t w;
		w.kind = k;
		w.status = s;
		w.d1 = a;
		w.d2 = c;
		w.cnt = n;
		w.sx = x;
		w.last = 1'b0;
		return w;
	endfunction

	// Appends one byte, or the pause mark, to the stimulus queue.
	function automatic void queue_byte(int b);
		stim_q = {stim_q, b};
	endfunction

	// Works out the result words that one raw byte causes and queues them.
	function automatic int assemble_byte(input logic [7:0] b);
		midi_word_t words[$];
		int         i;
		int         msg_length;
		bit         done;
		done = 1'b0;
		if (b >= moma_pkg::RT_FIRST) begin
			words = {words, make_word(moma_pkg::KIND_RT, b, 7'd0, 7'd0, 2'd0, 7'd0)};
		end else begin
			if (b[7]) begin
				if (run_status == moma_pkg::ST_SYSEX) begin
					if (fill_level < moma_pkg::SYSEX_MIN) begin
						words = {words, make_word(moma_pkg::KIND_SHORT, b, 7'd0, 7'd0,
							2'd0, 7'd0)};
						fill_level = 0;
					end else begin
						for (i = 0; i < fill_level; i++) begin
							words = {words, make_word(moma_pkg::KIND_SXB,
								moma_pkg::ST_SYSEX, 7'd0, 7'd0, 2'd0, byte_store[i])};
						end
						fill_level = 0;
						// An end-of-exclusive closes the run and leaves no running status.
						if (b == moma_pkg::ST_EOX) begin
							done = 1'b1;
							run_status = moma_pkg::ST_NONE;
						end
					end
				end
				if (!done) begin
					if (fill_level != 0) begin
						words = {words, make_word(moma_pkg::KIND_INTR, b, 7'd0, 7'd0,
							2'd0, 7'd0)};
						fill_level = 0;
					end
					run_status = b;
				end
			end else if (fill_level >= STORE_DEPTH) begin
				words = {words, make_word(moma_pkg::KIND_FULL, b, 7'd0, 7'd0, 2'd0, 7'd0)};
			end else begin
				byte_store[fill_level] = b[6:0];
				fill_level++;
			end
			if ((run_status >= 8'h80 && run_status <= 8'hBF) ||
					(run_status >= 8'hE0 && run_status <= 8'hEF) || run_status == 8'hF2) begin
				msg_length = 3;
			end else if ((run_status >= 8'hC0 && run_status <= 8'hDF) ||
					run_status == 8'hF1 || run_status == 8'hF3) begin
				msg_length = 2;
			end else if (run_status == 8'hF6) begin
				msg_length = 1;
			end else begin
				msg_length = 0;
			end
			if (!done && run_status != moma_pkg::ST_SYSEX && fill_level + 1 == msg_length)
					begin
				words = {words, make_word(moma_pkg::KIND_MSG, run_status,
					fill_level > 0 ? byte_store[0] : 7'd0,
					fill_level > 1 ? byte_store[1] : 7'd0, 2'(fill_level), 7'd0)};
				fill_level = 0;
			end
		end
		if (words.size() != 0) begin
			words[words.size() - 1].last = 1'b1;
		end
		expected_words = {expected_words, words};
		return words.size();
	endfunction

	function automatic int field_differs(string name, int want, int have);
		if (want != have) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, have);
			return 1;
		end
		return 0;
	endfunction

	// Data bytes now and then carry a realtime byte in between, as on a real port.
	task automatic push_data();
		if ($urandom_range(19) == 0) begin
			queue_byte($urandom_range(8'hFF, 8'hF8));
		end
		queue_byte($urandom_range(127));
	endtask

	task automatic add_sequence();
		int         pick;
		int         n;
		logic [7:0] st;
		pick = $urandom_range(99);
		if (pick < 40) begin
			// Channel message, sometimes relying on running status.
			if ($urandom_range(3) != 0) begin
				voice_status = 8'(8'h80 + $urandom_range(8'h6F));
				queue_byte(voice_status);
			end
			n = (voice_status[7:5] == 3'b110) ? 1 : 2;
			repeat (n) push_data();
		end else if (pick < 50) begin
			case ($urandom_range(3))
				0: begin
					queue_byte(8'hF1);
					push_data();
				end
				1: begin
					queue_byte(8'hF2);
					push_data();
					push_data();
				end
				2: begin
					queue_byte(8'hF3);
					push_data();
				end
				default: queue_byte(8'hF6);
			endcase
		end else if (pick < 65) begin
			queue_byte(moma_pkg::ST_SYSEX);
			n = ($urandom_range(9) == 0) ? $urandom_range(36, 20) : $urandom_range(8);
			repeat (n) push_data();
			if ($urandom_range(3) != 0) begin
				queue_byte(moma_pkg::ST_EOX);
			end else begin
				queue_byte($urandom_range(8'hF7, 8'h80));
			end
		end else if (pick < 72) begin
			queue_byte($urandom_range(8'hFF, 8'hF8));
		end else if (pick < 82) begin
			queue_byte($urandom_range(127));
		end else if (pick < 92) begin
			queue_byte($urandom_range(255));
		end else begin
			// A message cut short, which a later status byte interrupts unless a data byte completes it.
			st = 8'(8'h80 + $urandom_range(8'h6F));
			queue_byte(st);
			if (st[7:5] != 3'b110) begin
				push_data();
			end
		end
	endtask

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("midi_out_message_assembler_unit_test: errors");
			$finish;
		end
	end

	// Input driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			byte_in <= 8'h00;
			bytes_taken <= 0;
			words_predicted <= 0;
			run_status = moma_pkg::ST_NONE;
			fill_level = 0;
		end else begin
			drv_took = in_valid && !in_stall;
			if (drv_took) begin
				drv_words = assemble_byte(byte_in);
				words_predicted <= words_predicted + drv_words;
				bytes_taken <= bytes_taken + 1;
			end
			// A stalled word stays on the bus unchanged.
			if (!in_valid || drv_took) begin
				drv_next = 1'b0;
				if (stim_q.size() != 0 && stim_q[0] == PAUSE_MARK) begin
					if (!drv_took && words_predicted == words_seen) begin
						void'(stim_q.pop_front());
					end
				end else if (stim_q.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
					byte_in <= 8'(stim_q.pop_front());
					drv_next = 1'b1;
				end
				in_valid <= drv_next;
			end
		end
	end

	// Output monitor and stall control.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			words_seen <= 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got_word = make_word(moma_pkg::kind_t'(kind), status_byte, first_data,
					second_data, data_count, sysex_byte);
				got_word.last = last;
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word expected none actual kind %0d status %0h",
						$time, kind, status_byte);
					error_count++;
				end else begin
					want_word = expected_words.pop_front();
					error_count += field_differs("kind", want_word.kind, got_word.kind);
					error_count += field_differs("status_byte", want_word.status,
						got_word.status);
					error_count += field_differs("first_data", want_word.d1, got_word.d1);
					error_count += field_differs("second_data", want_word.d2, got_word.d2);
					error_count += field_differs("data_count", want_word.cnt, got_word.cnt);
					error_count += field_differs("sysex_byte", want_word.sx, got_word.sx);
					error_count += field_differs("last", want_word.last, got_word.last);
					words_seen <= words_seen + 1;
				end
			end
			// One long hold-off lets the block fill up and stall its input.
			if (!hold_done && bytes_taken >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && $urandom_range(99) < 8;
			end
		end
	end

	initial begin
		// Realtime, data without status, interrupted message, full messages, realtime
		// inside a message, one-byte message, never-complete status, short and full SysEx.
		stim_q = '{8'hF8, 8'hFF, 8'h05, 8'h90, 8'h00, 8'h7F, 8'h40, 8'hFE, 8'h41, 8'hC5,
			8'h7F, 8'hF6, 8'hF4, 8'h01, 8'hF0, 8'h01, 8'h02, 8'hF7, 8'hF0, 8'h10, 8'h11,
			8'h12, 8'h13, 8'hF7};
		// A SysEx that overruns the byte store.
		queue_byte(moma_pkg::ST_SYSEX);
		repeat (STORE_DEPTH + 4) queue_byte($urandom_range(127));
		queue_byte(moma_pkg::ST_EOX);
		while (stim_q.size() < ITEM_GOAL) begin
			add_sequence();
			if (!pause_placed && stim_q.size() >= 260) begin
				queue_byte(PAUSE_MARK);
				pause_placed = 1'b1;
			end
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		do @(negedge clk); while (stim_q.size() != 0 || in_valid);
		while (words_predicted != words_seen) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (error_count == 0) begin
			$display("midi_out_message_assembler_unit_test: clean");
		end else begin
			$display("midi_out_message_assembler_unit_test: errors");
		end
		$finish;
	end

endmodule

>>> midi_out_message_assembler_unit.f
rtl/moma_pkg.sv
rtl/moma_dp.sv
rtl/moma_ctrl.sv
rtl/midi_out_message_assembler_unit.sv
rtl/moma_chk.sv
verif/midi_out_message_assembler_unit_test.sv
